FILE: hw/rtl/combined_lcg_uniform_generator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the combined LCG uniform generator
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef COMBINED_LCG_UNIFORM_GENERATOR_CORE_DEFINES_SVH
`define COMBINED_LCG_UNIFORM_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property with a reset that masks it.
`define CLUG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clug assertion failed");
// Checked property that also holds while reset is asserted.
`define CLUG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("clug assertion failed");
`else
`define CLUG_ASSERT(label, clk, rst, prop)
`define CLUG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hw/rtl/clug_pkg.sv
// ---------------------------------------------------------------------------
// Combined LCG generator package
// Types, stream constants and sequencer states shared by the generator.
// ---------------------------------------------------------------------------
package clug_pkg;

  // The quotient s / a is taken as (s * recip) >> RECIP_SHIFT, then corrected.
  localparam int RECIP_SHIFT = 47;
  localparam int Q_W         = 16;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [31:0] m;
    logic [31:0] recip;
  } lane_const_t;

  localparam logic [63:0] ONE_RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd53668;
  localparam logic [63:0] TWO_RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd52774;

  localparam lane_const_t ONE_CONST = '{
    a:     16'd53668,
    b:     16'd40014,
    c:     16'd12211,
    m:     32'd2147483563,
    recip: ONE_RECIP_FULL[31:0]
  };

  localparam lane_const_t TWO_CONST = '{
    a:     16'd52774,
    b:     16'd40692,
    c:     16'd3791,
    m:     32'd2147483399,
    recip: TWO_RECIP_FULL[31:0]
  };

  localparam logic [31:0] WRAP_ADD = 32'd2147483562;

  typedef struct packed {
    logic load;   // take an item from the input
    logic recip;  // s * reciprocal
    logic aq;     // a * estimated quotient
    logic corr;   // remainder and quotient correction
    logic mulb;   // b * remainder
    logic mulc;   // c * quotient
    logic sub;    // new stream state
    logic out;    // write the result register
  } clug_cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RECIP = 8'b0000_0010,
    ST_AQ    = 8'b0000_0100,
    ST_CORR  = 8'b0000_1000,
    ST_MULB  = 8'b0001_0000,
    ST_MULC  = 8'b0010_0000,
    ST_SUB   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } clug_state_t;

endpackage

FILE: hw/rtl/clug_lane.sv
// ---------------------------------------------------------------------------
// Combined LCG stream lane
// One Schrage stream: a single shared multiplier stepped by the sequencer.
// ---------------------------------------------------------------------------
module clug_lane
  import clug_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  clug_cmd_t   cmd,
  input  logic        load,
  input  lane_const_t kc,
  input  logic [30:0] seed,
  output logic [30:0] value
);

  logic [63:0]    prod;
  logic [Q_W-1:0] q;
  logic [15:0]    rem;
  logic [31:0]    bq;

  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    mul_p;
  logic [Q_W-1:0] q_est;
  logic [31:0]    part_diff;
  logic [31:0]    rem_adj;
  logic           over;
  logic [31:0]    r_raw;
  logic [31:0]    r_fix;

  assign q_est = prod[RECIP_SHIFT +: Q_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.recip) begin
      mul_a = {1'b0, value};
      mul_b = kc.recip;
    end else if (cmd.aq) begin
      mul_a = {16'b0, q_est};
      mul_b = {16'b0, kc.a};
    end else if (cmd.mulb) begin
      mul_a = {16'b0, rem};
      mul_b = {16'b0, kc.b};
    end else if (cmd.mulc) begin
      mul_a = {16'b0, q};
      mul_b = {16'b0, kc.c};
    end
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // The estimate is the true quotient or one below, so the remainder is under 2a.
  assign part_diff = {1'b0, value} - prod[31:0];
  assign over      = part_diff >= {16'b0, kc.a};
  assign rem_adj   = part_diff - {16'b0, kc.a};

  // A negative difference wraps mod 2^32; adding m brings it back into range.
  assign r_raw = bq - prod[31:0];
  assign r_fix = (bq < prod[31:0]) ? (r_raw + kc.m) : r_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= 31'd1;
    end else if (load) begin
      value <= seed;
    end else if (cmd.sub) begin
      value <= r_fix[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.recip || cmd.aq || cmd.mulb || cmd.mulc) begin
      prod <= mul_p;
    end
    if (cmd.aq) begin
      q <= q_est;
    end
    if (cmd.corr) begin
      if (over) begin
        rem <= rem_adj[15:0];
        q   <= q + 1'b1;
      end else begin
        rem <= part_diff[15:0];
      end
    end
    if (cmd.mulc) begin
      bq <= prod[31:0];
    end
  end

endmodule

FILE: hw/rtl/clug_datapath.sv
// ---------------------------------------------------------------------------
// Combined LCG datapath
// Two stream lanes, the combining subtract and the result register.
// ---------------------------------------------------------------------------
module clug_datapath
  import clug_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  clug_cmd_t   cmd,
  input  logic        kind,
  input  logic [30:0] seed_one,
  input  logic [30:0] seed_two,
  output logic [30:0] uniform_value,
  output logic        seed_loaded
);

  logic        seed_item;
  logic        lane_load;
  logic [30:0] first_stream;
  logic [30:0] second_stream;
  logic [31:0] z_raw;
  logic [31:0] z_fix;

  assign lane_load = cmd.load & kind;

  clug_lane u_lane_one (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .load  (lane_load),
    .kc    (ONE_CONST),
    .seed  (seed_one),
    .value (first_stream)
  );

  clug_lane u_lane_two (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .load  (lane_load),
    .kc    (TWO_CONST),
    .seed  (seed_two),
    .value (second_stream)
  );

  // When the first stream does not exceed the second, z < 1 and is lifted.
  assign z_raw = {1'b0, first_stream} - {1'b0, second_stream};
  assign z_fix = (first_stream <= second_stream) ? (z_raw + WRAP_ADD) : z_raw;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed_item <= kind;
    end
    if (cmd.out) begin
      uniform_value <= seed_item ? 31'd0 : z_fix[30:0];
      seed_loaded   <= seed_item;
    end
  end

endmodule

FILE: hw/rtl/clug_ctrl.sv
// ---------------------------------------------------------------------------
// Combined LCG controller
// Sequencer for the Schrage steps and the input and output handshakes.
// ---------------------------------------------------------------------------
`include "combined_lcg_uniform_generator_core_defines.svh"

module clug_ctrl
  import clug_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      kind,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output clug_cmd_t cmd
);

  clug_state_t state;
  clug_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = kind ? ST_DONE : ST_RECIP;
        end
      end
      ST_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = ST_AQ;
      end
      ST_AQ: begin
        cmd.aq     = 1'b1;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr   = 1'b1;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        cmd.mulb   = 1'b1;
        state_next = ST_MULC;
      end
      ST_MULC: begin
        cmd.mulc   = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register has room.
        if (out_free) begin
          cmd.out    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CLUG_ASSERT(a_draw_starts, clk, rst, (state == ST_IDLE && in_valid && !kind) |=> (state == ST_RECIP))
  `CLUG_ASSERT(a_done_delivers, clk, rst, (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
  `CLUG_ASSERT(a_done_holds, clk, rst, (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE))

endmodule

FILE: hw/rtl/combined_lcg_uniform_generator_core.sv
// ---------------------------------------------------------------------------
// Combined LCG uniform generator core
// Two-stream Schrage generator returning a 31-bit uniform fraction per draw.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                           | tuser
//  s_axis  | in        | seed_one[30:0], seed_two[61:31] | kind[0]
//  m_axis  | out       | uniform_value[30:0]             | seed_loaded[0]
//
//  A draw item passes from acceptance through six steps of the per-stream
//  multiplier sequence (reciprocal, a*q, correction, b*r, c*q, subtract) and
//  the result step before the next ready; a seed item skips the six steps.
//  Reset (rst, synchronous) sets both streams to 1 and empties the output.
//  A result held by a stalled m_axis keeps the block in its final step; the
//  next item is accepted as soon as that result moves to the output register.
// ---------------------------------------------------------------------------
module combined_lcg_uniform_generator_core
  import clug_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // seed_one[30:0], seed_two[61:31], zero fill
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // uniform_value[30:0], zero fill
  output logic [0:0]  m_tuser    // seed_loaded[0]
);

  clug_cmd_t   cmd;
  logic [30:0] uniform_value;
  logic        seed_loaded;

  clug_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .kind      (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  clug_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (s_tuser[0]),
    .seed_one      (s_tdata[30:0]),
    .seed_two      (s_tdata[61:31]),
    .uniform_value (uniform_value),
    .seed_loaded   (seed_loaded)
  );

  assign m_tdata = {1'b0, uniform_value};
  assign m_tuser = seed_loaded;

endmodule
